>>> rtl/core/sbv_pkg.sv
// Shared types, constants and character helpers for the service banner verifier.
// Used by service_banner_verifier_top; depends on nothing else.
package sbv_pkg;

   // Service mode codes held in the mode register.
   typedef enum logic [2:0] {
      MODE_NONE     = 3'd0,
      MODE_HTTP     = 3'd1,
      MODE_SSH      = 3'd2,
      MODE_FTP      = 3'd3,
      MODE_SMTP     = 3'd4,
      MODE_STARTTLS = 3'd5,
      MODE_RSVD6    = 3'd6,
      MODE_RSVD7    = 3'd7
   } mode_type;

   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;

   // Keyword match states for the STARTTLS body.
   localparam logic [3:0] KW_FULL  = 4'd8;
   localparam logic [3:0] KW_TRAIL = 4'd9;
   localparam logic [3:0] KW_FAIL  = 4'd15;

   // Matcher state carried from one word to the next.
   typedef struct packed {
      logic [3:0] prefix_position;
      logic [3:0] status_phase;
      logic [2:0] token_position;
      logic       previous_alphanumeric;
      logic       token_found;
      logic       first_line_over;
      logic       line_has_text;
      logic       whitespace_pending;
      logic       reply_line_seen;
      logic       keyword_line_seen;
      logic       last_line_final;
      logic [3:0] keyword_position;
      logic       match_failed;
   } match_state_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alnum(input logic [7:0] u);
      return (u >= "A" && u <= "Z") || is_digit(u);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] http_char(input logic [3:0] i);
      case (i)
         4'd0: return "H";
         4'd1: return "T";
         4'd2: return "T";
         4'd3: return "P";
         4'd4: return "/";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] ssh_char(input logic [3:0] i);
      case (i)
         4'd0: return "S";
         4'd1: return "S";
         4'd2: return "H";
         4'd3: return "-";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] ftp_char(input logic [2:0] i);
      case (i)
         3'd0: return "F";
         3'd1: return "T";
         3'd2: return "P";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] smtp_char(input logic [2:0] i);
      case (i)
         3'd0: return "S";
         3'd1: return "M";
         3'd2: return "T";
         3'd3: return "P";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] esmtp_char(input logic [3:0] i);
      case (i)
         4'd0: return "E";
         4'd1: return "S";
         4'd2: return "M";
         4'd3: return "T";
         4'd4: return "P";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] starttls_char(input logic [3:0] i);
      case (i)
         4'd0: return "S";
         4'd1: return "T";
         4'd2: return "A";
         4'd3: return "R";
         4'd4: return "T";
         4'd5: return "T";
         4'd6: return "L";
         4'd7: return "S";
         default: return 8'h00;
      endcase
   endfunction

endpackage

>>> rtl/core/service_banner_verifier_top.sv
// Top level of the service banner verifier: input register, matcher logic, result register.
// Depends on sbv_pkg for types, constants and character helpers.
//
// Usage: the req_ channel carries one word per response byte (req_data_byte with
// req_has_byte high), and req_last_byte marks the final word of a response. A word
// with req_has_byte low and req_last_byte high closes a response without a byte.
// On each final word one result word leaves on the rsp_ channel: rsp_verified is 1
// when the response proves the service chosen by the mode register.
// The mode register is written through csr_write_enable and csr_write_data; the user
// must write it only while the block is idle, which the block does not enforce. A write
// also clears any response in progress. A word is captured in the input register and
// runs through the matcher from there; a final word's result word is then registered.
// Throughput: one word per cycle while no final word waits on a held result, set by the
// single pass of matcher logic between the input register and the state registers.
// A stall on rsp_ holds the result register; a final word that then reaches the
// input register waits there and raises req_stall, so no word is lost. Words that
// are not final keep flowing while a result waits.
// Reset clears the mode to none, the matcher state and both valid flags.
module service_banner_verifier_top
   import sbv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_has_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_verified,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_write_data
);

   mode_type        mode_ff;
   logic            in_valid_ff;
   logic [7:0]      in_data_ff;
   logic            in_has_ff;
   logic            in_last_ff;
   match_state_type st_ff, st_in;
   logic            out_valid_ff;
   logic            out_verified_ff;
   logic            ok_in;
   logic            proc_go;

   // A buffered word proceeds unless it is final and the result slot is held.
   assign proc_go   = in_valid_ff && !(in_last_ff && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !proc_go;
   assign rsp_valid    = out_valid_ff;
   assign rsp_verified = out_verified_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (proc_go) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
         in_has_ff  <= req_has_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // Mode register and matcher state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
         st_ff   <= '0;
      end else if (csr_write_enable) begin
         mode_ff <= mode_type'(csr_write_data);
         st_ff   <= '0;
      end else if (proc_go) begin
         st_ff <= in_last_ff ? '0 : st_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc_go && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (proc_go && in_last_ff) begin
         out_verified_ff <= ok_in;
      end
   end

   // Matcher: one byte of state update, then the end-of-response verdict.
   always_comb begin
      logic [7:0] c;
      logic [7:0] u;
      logic       greet;
      logic       an;
      match_state_type s;
      c = in_data_ff;
      u = to_upper(c);
      s = st_ff;
      greet = (mode_ff == MODE_FTP) || (mode_ff == MODE_SMTP);
      an = is_alnum(u);
      ok_in = 1'b0;

      if (in_has_ff) begin
         if (mode_ff == MODE_HTTP || mode_ff == MODE_SSH || greet) begin
            // First line only.
            if (!s.first_line_over) begin
               if (c == CH_LF) begin
                  if (greet) begin
                     if (mode_ff == MODE_FTP) begin
                        if (s.token_position == 3'd3) s.token_found = 1'b1;
                     end else if (s.token_position == 3'd4 || s.keyword_position == 4'd5) begin
                        s.token_found = 1'b1;
                     end
                  end
                  s.first_line_over = 1'b1;
               end else if (s.line_has_text || !is_ws(c)) begin
                  s.line_has_text = 1'b1;
                  if (!s.match_failed) begin
                     if (mode_ff == MODE_HTTP) begin
                        case (s.status_phase)
                           4'd0: begin
                              if (s.prefix_position < 4'd5 && u == http_char(s.prefix_position)) begin
                                 s.prefix_position = s.prefix_position + 4'd1;
                                 if (s.prefix_position == 4'd5) s.status_phase = 4'd1;
                              end else s.match_failed = 1'b1;
                           end
                           4'd1: if (is_digit(u)) s.status_phase = 4'd2;
                                 else s.match_failed = 1'b1;
                           4'd2: begin
                              if (is_digit(u)) s.status_phase = 4'd2;
                              else if (u == CH_DOT) s.status_phase = 4'd3;
                              else if (u == CH_SPACE) s.status_phase = 4'd5;
                              else s.match_failed = 1'b1;
                           end
                           4'd3: if (is_digit(u)) s.status_phase = 4'd4;
                                 else s.match_failed = 1'b1;
                           4'd4: begin
                              if (is_digit(u)) s.status_phase = 4'd4;
                              else if (u == CH_SPACE) s.status_phase = 4'd5;
                              else s.match_failed = 1'b1;
                           end
                           4'd5: if (u >= "1" && u <= "5") s.status_phase = 4'd6;
                                 else s.match_failed = 1'b1;
                           4'd6: if (is_digit(u)) s.status_phase = 4'd7;
                                 else s.match_failed = 1'b1;
                           4'd7: if (is_digit(u)) s.status_phase = 4'd8;
                                 else s.match_failed = 1'b1;
                           4'd8: begin
                              if (!s.whitespace_pending && u == CH_SPACE) s.status_phase = 4'd10;
                              else if (is_ws(u)) s.whitespace_pending = 1'b1;
                              else s.match_failed = 1'b1;
                           end
                           default: s.status_phase = s.status_phase;
                        endcase
                     end else if (mode_ff == MODE_SSH) begin
                        if (s.prefix_position < 4'd4) begin
                           if (c == ssh_char(s.prefix_position))
                              s.prefix_position = s.prefix_position + 4'd1;
                           else s.match_failed = 1'b1;
                        end
                     end else begin
                        // Greeting prefix "220 " or "220-".
                        if (s.prefix_position < 4'd3) begin
                           if (u == ((s.prefix_position == 4'd0) ? "2" :
                                     (s.prefix_position == 4'd1) ? "2" : "0"))
                              s.prefix_position = s.prefix_position + 4'd1;
                           else s.match_failed = 1'b1;
                        end else if (s.prefix_position == 4'd3) begin
                           if (u == CH_SPACE || u == CH_DASH) s.prefix_position = 4'd4;
                           else s.match_failed = 1'b1;
                        end
                        // Token search with word boundaries.
                        if (mode_ff == MODE_FTP) begin
                           if (s.token_position >= 3'd3) begin
                              if (!an) s.token_found = 1'b1;
                              s.token_position = 3'd0;
                              if (!s.previous_alphanumeric && u == ftp_char(3'd0))
                                 s.token_position = 3'd1;
                           end else if (s.token_position > 3'd0 &&
                                        u == ftp_char(s.token_position)) begin
                              s.token_position = s.token_position + 3'd1;
                           end else begin
                              s.token_position = 3'd0;
                              if (!s.previous_alphanumeric && u == ftp_char(3'd0))
                                 s.token_position = 3'd1;
                           end
                        end else begin
                           if (s.token_position >= 3'd4) begin
                              if (!an) s.token_found = 1'b1;
                              s.token_position = 3'd0;
                              if (!s.previous_alphanumeric && u == smtp_char(3'd0))
                                 s.token_position = 3'd1;
                           end else if (s.token_position > 3'd0 &&
                                        u == smtp_char(s.token_position)) begin
                              s.token_position = s.token_position + 3'd1;
                           end else begin
                              s.token_position = 3'd0;
                              if (!s.previous_alphanumeric && u == smtp_char(3'd0))
                                 s.token_position = 3'd1;
                           end
                           if (s.keyword_position >= 4'd5) begin
                              if (!an) s.token_found = 1'b1;
                              s.keyword_position = 4'd0;
                              if (!s.previous_alphanumeric && u == esmtp_char(4'd0))
                                 s.keyword_position = 4'd1;
                           end else if (s.keyword_position > 4'd0 &&
                                        u == esmtp_char(s.keyword_position)) begin
                              s.keyword_position = s.keyword_position + 4'd1;
                           end else begin
                              s.keyword_position = 4'd0;
                              if (!s.previous_alphanumeric && u == esmtp_char(4'd0))
                                 s.keyword_position = 4'd1;
                           end
                        end
                        s.previous_alphanumeric = an;
                     end
                  end
               end
            end
         end else if (mode_ff == MODE_STARTTLS) begin
            // Multi-line reply check.
            if (!s.match_failed) begin
               if (c == CH_LF) begin
                  if (s.line_has_text) begin
                     if (s.prefix_position < 4'd5) s.match_failed = 1'b1;
                     else begin
                        s.reply_line_seen = 1'b1;
                        s.last_line_final = (s.prefix_position == 4'd6);
                        if (s.keyword_position == KW_FULL || s.keyword_position == KW_TRAIL)
                           s.keyword_line_seen = 1'b1;
                     end
                  end
                  s.line_has_text    = 1'b0;
                  s.prefix_position  = 4'd0;
                  s.keyword_position = 4'd0;
               end else if (s.line_has_text || !is_ws(c)) begin
                  s.line_has_text = 1'b1;
                  if (s.prefix_position < 4'd3) begin
                     if (u == ((s.prefix_position == 4'd0) ? "2" :
                               (s.prefix_position == 4'd1) ? "5" : "0"))
                        s.prefix_position = s.prefix_position + 4'd1;
                     else s.match_failed = 1'b1;
                  end else if (s.prefix_position == 4'd3) begin
                     if (u == CH_DASH) s.prefix_position = 4'd5;
                     else if (u == CH_SPACE) s.prefix_position = 4'd4;
                     else s.match_failed = 1'b1;
                  end else begin
                     if (s.keyword_position != KW_FAIL) begin
                        if (is_ws(u)) begin
                           if (s.keyword_position != 4'd0)
                              s.keyword_position = (s.keyword_position >= KW_FULL) ?
                                                   KW_TRAIL : KW_FAIL;
                        end else if (s.keyword_position < KW_FULL &&
                                     u == starttls_char(s.keyword_position)) begin
                           s.keyword_position = s.keyword_position + 4'd1;
                        end else begin
                           s.keyword_position = KW_FAIL;
                        end
                     end
                     if (s.prefix_position == 4'd4 && !is_ws(u)) s.prefix_position = 4'd6;
                  end
               end
            end
         end
      end

      // The state carried forward excludes the line closing done for the verdict.
      st_in = s;

      // End-of-response verdict.
      if (mode_ff == MODE_HTTP) begin
         ok_in = !s.match_failed && s.status_phase >= 4'd8;
      end else if (mode_ff == MODE_SSH) begin
         ok_in = !s.match_failed && s.prefix_position == 4'd4;
      end else if (greet) begin
         if (!s.first_line_over) begin
            if (mode_ff == MODE_FTP) begin
               if (s.token_position == 3'd3) s.token_found = 1'b1;
            end else if (s.token_position == 3'd4 || s.keyword_position == 4'd5) begin
               s.token_found = 1'b1;
            end
         end
         ok_in = !s.match_failed && s.prefix_position == 4'd4 && s.token_found;
      end else if (mode_ff == MODE_STARTTLS) begin
         if (!s.match_failed && s.line_has_text) begin
            if (s.prefix_position < 4'd5) s.match_failed = 1'b1;
            else begin
               s.reply_line_seen = 1'b1;
               s.last_line_final = (s.prefix_position == 4'd6);
               if (s.keyword_position == KW_FULL || s.keyword_position == KW_TRAIL)
                  s.keyword_line_seen = 1'b1;
            end
         end
         ok_in = !s.match_failed && s.reply_line_seen && s.keyword_line_seen &&
                 s.last_line_final;
      end
   end

`ifndef SYNTH
   // A held result word keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verified))
      else $error("result changed while stalled");
   // A final word processed always produces a result word.
   assert property (@(posedge clock) disable iff (reset)
      proc_go && in_last_ff |=> out_valid_ff)
      else $error("final word produced no result");
   // Matcher state is clear after a response ends.
   assert property (@(posedge clock) disable iff (reset)
      proc_go && in_last_ff && !csr_write_enable |=> st_ff == '0)
      else $error("state not cleared after response");
   // A result in the unused or none modes is never verified.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode_ff == MODE_NONE || mode_ff == MODE_RSVD6 || mode_ff == MODE_RSVD7)
      |-> !rsp_verified)
      else $error("verified in a mode that cannot verify");
`endif

endmodule

>>> test/tb_service_banner_verifier_top.sv
// Testbench for service_banner_verifier_top: directed and random responses in every mode.
// Depends on sbv_pkg and the block; holds its own banner matcher to predict each result.
`timescale 1ns / 1ps

module tb_service_banner_verifier_top
   import sbv_pkg::*;
();

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_has_byte = 1'b0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_verified;
   logic       csr_write_enable = 1'b0;
   logic [2:0] csr_write_data = 3'd0;

   service_banner_verifier_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_has_byte(req_has_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_verified(rsp_verified),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted verdicts waiting for their result words.
   logic       verdict_q[$];
   int         fail_count = 0;
   int         words_sent = 0;
   int         verdicts_seen = 0;
   bit         calm = 1'b0;
   bit         hold_go = 1'b0;
   logic [7:0] msg[$];

   // Matcher state of the banner predictor.
   mode_type   cur_mode = MODE_NONE;
   logic [3:0] m_prefix, m_phase, m_kw;
   logic [2:0] m_tok;
   logic       m_prev_an, m_found, m_first_done, m_has_text, m_ws_pend;
   logic       m_reply_seen, m_kw_seen, m_last_final, m_failed;

   function automatic bit blank(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   function automatic bit alnum_up(logic [7:0] u);
      return (u >= 8'd65 && u <= 8'd90) || digit(u);
   endfunction

   function automatic logic [7:0] upcase(logic [7:0] c);
      return (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] char_at(string s, int p);
      return (p < s.len()) ? s[p] : 8'h00;
   endfunction

   task automatic clear_matcher();
      m_prefix = 0; m_phase = 0; m_kw = 0; m_tok = 0;
      m_prev_an = 0; m_found = 0; m_first_done = 0; m_has_text = 0; m_ws_pend = 0;
      m_reply_seen = 0; m_kw_seen = 0; m_last_final = 0; m_failed = 0;
   endtask

   // Token tracker: the token counts only after a non-alphanumeric or the line start.
   task automatic token_track(inout int pos, input string tok, input logic [7:0] u);
      if (pos >= tok.len()) begin
         if (!alnum_up(u)) m_found = 1;
         pos = 0;
      end else if (pos > 0 && u == char_at(tok, pos)) begin
         pos = pos + 1;
         return;
      end else begin
         pos = 0;
      end
      if (!m_prev_an && u == char_at(tok, 0)) pos = 1;
   endtask

   task automatic http_track(logic [7:0] u);
      case (m_phase)
         4'd0: begin
            if (m_prefix < 5 && u == char_at("HTTP/", m_prefix)) begin
               m_prefix = m_prefix + 1;
               if (m_prefix == 5) m_phase = 1;
            end else m_failed = 1;
         end
         4'd1: if (digit(u)) m_phase = 2; else m_failed = 1;
         4'd2: begin
            if (digit(u)) ;
            else if (u == ".") m_phase = 3;
            else if (u == " ") m_phase = 5;
            else m_failed = 1;
         end
         4'd3: if (digit(u)) m_phase = 4; else m_failed = 1;
         4'd4: begin
            if (digit(u)) ;
            else if (u == " ") m_phase = 5;
            else m_failed = 1;
         end
         4'd5: if (u >= "1" && u <= "5") m_phase = 6; else m_failed = 1;
         4'd6: if (digit(u)) m_phase = 7; else m_failed = 1;
         4'd7: if (digit(u)) m_phase = 8; else m_failed = 1;
         4'd8: begin
            if (!m_ws_pend && u == " ") m_phase = 10;
            else if (blank(u)) m_ws_pend = 1;
            else m_failed = 1;
         end
         default: ;
      endcase
   endtask

   task automatic greeting_track(logic [7:0] u);
      int tp, kp;
      if (m_prefix < 3) begin
         if (u == char_at("220", m_prefix)) m_prefix = m_prefix + 1; else m_failed = 1;
      end else if (m_prefix == 3) begin
         if (u == " " || u == "-") m_prefix = 4; else m_failed = 1;
      end
      tp = m_tok;
      kp = m_kw;
      if (cur_mode == MODE_FTP) begin
         token_track(tp, "FTP", u);
      end else begin
         token_track(tp, "SMTP", u);
         token_track(kp, "ESMTP", u);
      end
      m_tok = tp;
      m_kw = kp;
      m_prev_an = alnum_up(u);
   endtask

   task automatic greeting_close();
      if (cur_mode == MODE_FTP) begin
         if (m_tok == 3) m_found = 1;
      end else if (m_tok == 4 || m_kw == 5) begin
         m_found = 1;
      end
   endtask

   task automatic first_line_track(logic [7:0] c);
      logic [7:0] u;
      u = upcase(c);
      if (m_first_done) return;
      if (c == 8'd10) begin
         if (cur_mode == MODE_FTP || cur_mode == MODE_SMTP) greeting_close();
         m_first_done = 1;
         return;
      end
      if (!m_has_text && blank(c)) return;
      m_has_text = 1;
      if (m_failed) return;
      if (cur_mode == MODE_HTTP) http_track(u);
      else if (cur_mode == MODE_SSH) begin
         if (m_prefix < 4) begin
            if (c == char_at("SSH-", m_prefix)) m_prefix = m_prefix + 1; else m_failed = 1;
         end
      end else greeting_track(u);
   endtask

   // STARTTLS body: leading blanks, the keyword, then only trailing blanks.
   task automatic keyword_track(logic [7:0] u);
      if (m_kw == KW_FAIL) return;
      if (blank(u)) begin
         if (m_kw == 0) return;
         m_kw = (m_kw >= KW_FULL) ? KW_TRAIL : KW_FAIL;
      end else if (m_kw < KW_FULL && u == char_at("STARTTLS", m_kw)) begin
         m_kw = m_kw + 1;
      end else begin
         m_kw = KW_FAIL;
      end
   endtask

   task automatic reply_line_close();
      if (m_has_text) begin
         if (m_prefix < 5) m_failed = 1;
         else begin
            m_reply_seen = 1;
            m_last_final = (m_prefix == 6);
            if (m_kw == KW_FULL || m_kw == KW_TRAIL) m_kw_seen = 1;
         end
      end
      m_has_text = 0;
      m_prefix = 0;
      m_kw = 0;
   endtask

   task automatic reply_track(logic [7:0] c);
      logic [7:0] u;
      u = upcase(c);
      if (m_failed) return;
      if (c == 8'd10) begin
         reply_line_close();
         return;
      end
      if (!m_has_text && blank(c)) return;
      m_has_text = 1;
      if (m_prefix < 3) begin
         if (u == char_at("250", m_prefix)) m_prefix = m_prefix + 1; else m_failed = 1;
      end else if (m_prefix == 3) begin
         if (u == "-") m_prefix = 5;
         else if (u == " ") m_prefix = 4;
         else m_failed = 1;
      end else begin
         keyword_track(u);
         if (m_prefix == 4 && !blank(u)) m_prefix = 6;
      end
   endtask

   // Predicts the effect of one accepted word and queues the verdict on a final word.
   task automatic predict_word(logic [7:0] c, logic has, logic last);
      logic ok;
      bit first_modes;
      ok = 0;
      first_modes = cur_mode inside {MODE_HTTP, MODE_SSH, MODE_FTP, MODE_SMTP};
      if (has) begin
         if (first_modes) first_line_track(c);
         else if (cur_mode == MODE_STARTTLS) reply_track(c);
      end
      if (!last) return;
      if (first_modes) begin
         if (!m_first_done && (cur_mode == MODE_FTP || cur_mode == MODE_SMTP))
            greeting_close();
         if (cur_mode == MODE_HTTP) ok = !m_failed && m_phase >= 8;
         else if (cur_mode == MODE_SSH) ok = !m_failed && m_prefix == 4;
         else ok = !m_failed && m_prefix == 4 && m_found;
      end else if (cur_mode == MODE_STARTTLS) begin
         if (!m_failed) reply_line_close();
         ok = !m_failed && m_reply_seen && m_kw_seen && m_last_final;
      end
      verdict_q.push_back(ok);
      clear_matcher();
   endtask

   // Sends one word; returns at a rising edge after it was accepted and any gap.
   task automatic send_word(logic [7:0] c, logic has, logic last);
      int gap;
      req_data_byte <= c;
      req_has_byte <= has;
      req_last_byte <= last;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_word(c, has, last);
      words_sent++;
      if (!calm && $urandom_range(99) < 38) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(mode_type m);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_mode = m;
      clear_matcher();
   endtask

   task automatic add(string s);
      for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
   endtask

   // Sends the message buffer as one response, closed by its last byte or an empty word.
   task automatic send_msg(bit close_empty, bit with_idle);
      for (int i = 0; i < msg.size(); i++) begin
         if (with_idle && $urandom_range(19) == 0)
            send_word(8'($urandom_range(255)), 1'b0, 1'b0);
         send_word(msg[i], 1'b1, !close_empty && i == msg.size() - 1);
      end
      if (close_empty || msg.size() == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic send_text(string s);
      msg.delete();
      add(s);
      send_msg(1'b0, 1'b0);
   endtask

   task automatic add_digits(int n);
      repeat (n) msg.push_back(8'd48 + 8'($urandom_range(9)));
   endtask

   task automatic gen_http();
      if ($urandom_range(5) == 0) add(" \t");
      add("HTTP/");
      add_digits($urandom_range(1, 2));
      if ($urandom_range(1)) begin
         add(".");
         add_digits($urandom_range(1, 2));
      end
      add(" ");
      msg.push_back(8'd49 + 8'($urandom_range(4)));
      add_digits(2);
      case ($urandom_range(4))
         0: add(" OK");
         1: ;
         2: add("\t");
         3: add("  x");
         default: add("x");
      endcase
      add("\r\n");
      if ($urandom_range(1)) add("Server: a\r\n");
   endtask

   task automatic gen_ssh();
      if ($urandom_range(4) == 0) add("  ");
      add($urandom_range(6) == 0 ? "ssh-" : "SSH-");
      add("2.0-srv\r\n");
   endtask

   task automatic gen_greeting(bit smtp);
      string pre[4] = '{"mail ", "x", "(", ""};
      string post[5] = '{" ready", "d", ")", "", "1"};
      add($urandom_range(1) ? "220 " : "220-");
      add(pre[$urandom_range(3)]);
      if (smtp) add($urandom_range(1) ? "SMTP" : "ESMTP");
      else add("FTP");
      add(post[$urandom_range(4)]);
      if ($urandom_range(2) != 0) add("\r\n");
      if ($urandom_range(2) == 0) add("220 FTP SMTP\n");
   endtask

   task automatic gen_reply();
      string body[5] = '{"host", "STARTTLS", "PIPELINING", " starttls  ", "SIZE 10"};
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(7) == 0) add("  \r\n");
         add((i == n - 1 && $urandom_range(5) != 0) ? "250 " : "250-");
         add(body[$urandom_range(4)]);
         if (i < n - 1 || $urandom_range(1)) begin
            if ($urandom_range(1)) add("\r\n");
            else add("\n");
         end
      end
   endtask

   task automatic gen_noise();
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(255)));
   endtask

   // Builds one response, mostly well formed for the mode, then perhaps lowercases letters and damages a byte.
   task automatic gen_response(mode_type m);
      int kind;
      msg.delete();
      kind = ($urandom_range(99) < 80) ? int'(m) : $urandom_range(0, 5);
      case (kind)
         1: gen_http();
         2: gen_ssh();
         3: gen_greeting(1'b0);
         4: gen_greeting(1'b1);
         5: gen_reply();
         default: gen_noise();
      endcase
      if (kind != 2 && kind != 5)
         foreach (msg[i])
            if (msg[i] >= "A" && msg[i] <= "Z" && $urandom_range(3) == 0)
               msg[i] = msg[i] + 8'd32;
      if (msg.size() > 0 && $urandom_range(3) == 0)
         msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
   endtask

   task automatic test_directed();
      write_mode(MODE_HTTP);
      send_word(8'h00, 1'b0, 1'b1);
      send_text("HTTP/1.1 200 OK\r\n");
      send_word(8'hff, 1'b0, 1'b0);
      send_text("HTTP/1 599");
      write_mode(MODE_SSH);
      send_text("SSH-");
      send_word(8'hff, 1'b1, 1'b1);
      write_mode(MODE_FTP);
      send_text("220 FTP");
      write_mode(MODE_SMTP);
      msg.delete();
      add("220-ESMTP");
      send_msg(1'b1, 1'b0);
      write_mode(MODE_STARTTLS);
      send_text("250-STARTTLS\n250 ok");
      // A partial response is dropped by the mode write that follows.
      send_word("2", 1'b1, 1'b0);
      write_mode(MODE_RSVD7);
      send_text("SSH-");
      write_mode(MODE_RSVD6);
      send_text("x");
   endtask

   // The receiver holds off while the sender keeps offering words.
   task automatic test_backpressure();
      write_mode(MODE_STARTTLS);
      calm = 1'b1;
      hold_go = 1'b1;
      repeat (15) begin
         msg.delete();
         gen_reply();
         send_msg(1'b0, 1'b0);
      end
      calm = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_modes();
      mode_type order[10] = '{MODE_HTTP, MODE_SSH, MODE_FTP, MODE_SMTP, MODE_STARTTLS,
                              MODE_NONE, MODE_RSVD6, MODE_RSVD7, MODE_STARTTLS, MODE_HTTP};
      int target;
      foreach (order[k]) begin
         write_mode(order[k]);
         calm = (k == 3);
         target = words_sent + 125;
         while (words_sent < target) begin
            gen_response(order[k]);
            send_msg($urandom_range(9) == 0, 1'b1);
         end
      end
      calm = 1'b0;
   endtask

   // Result checker and receiver stall generator.
   always @(posedge clock) begin
      static int hold_left = 0;
      if (rsp_valid && !rsp_stall) begin
         verdicts_seen++;
         if (verdict_q.size() == 0) begin
            $error("unexpected result word, verified actual %0d", rsp_verified);
            fail_count++;
         end else begin
            logic want;
            want = verdict_q.pop_front();
            if (rsp_verified !== want) begin
               $error("verified expected %0d actual %0d", want, rsp_verified);
               fail_count++;
            end
         end
      end
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left = 200;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (calm || reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 38);
      end
   end

   initial begin
      clear_matcher();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_modes();
      wait_drained();
      repeat (10) @(posedge clock);
      if (verdict_q.size() != 0) begin
         $error("%0d verdicts never arrived", verdict_q.size());
         fail_count++;
      end
      $display("Sent %0d words across all service modes, checked %0d verdicts.",
               words_sent, verdicts_seen);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/sbv_pkg.sv
rtl/core/service_banner_verifier_top.sv
test/tb_service_banner_verifier_top.sv
